### design/zfr_pkg.sv
// Package for the ZMODEM frame receiver: constants, phase type, CRC byte functions.
// No dependencies.
package zfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;

  localparam logic [7:0] PAD_CH  = 8'h2A;
  localparam logic [7:0] DLE_CH  = 8'h18;
  localparam logic [7:0] FMT_HEX = 8'h42;
  localparam logic [7:0] FMT_B16 = 8'h41;
  localparam logic [7:0] FMT_B32 = 8'h43;
  localparam logic [7:0] END_E   = 8'h68;
  localparam logic [7:0] END_G   = 8'h69;
  localparam logic [7:0] END_Q   = 8'h6A;
  localparam logic [7:0] END_W   = 8'h6B;
  localparam logic [7:0] TYPE_FILE = 8'd4;
  localparam logic [7:0] TYPE_DATA = 8'd10;
  localparam logic [3:0] HDR_NIBBLES = 4'd14;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_HDR  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [1:0] ERR_HEX   = 2'd0;
  localparam logic [1:0] ERR_HCRC  = 2'd1;
  localparam logic [1:0] ERR_TMO   = 2'd2;
  localparam logic [1:0] ERR_SCRC  = 2'd3;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_MANY = 2'd2;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_PAD1    = 9'b000000010,
    PH_PAD2    = 9'b000000100,
    PH_FMT     = 9'b000001000,
    PH_HEX     = 9'b000010000,
    PH_HEXBAD  = 9'b000100000,
    PH_BHDR    = 9'b001000000,
    PH_SUBDATA = 9'b010000000,
    PH_SUBCRC  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [7:0]  frame_type;
    logic [31:0] frame_flags;
    logic        used_crc32;
    logic [7:0]  ender_code;
    logic [10:0] payload_len;
    logic [1:0]  error_code;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

endpackage

### design/zmodem_frame_receiver.sv
// ZMODEM frame receiver top level: header hunt, unescape, CRC check, subpacket parse.
// Depends on zfr_pkg.
//
// Input channel in_*: one beat per received byte; in_tdata[7:0] is the raw
// byte, in_tuser marks a read timeout taking the place of a byte.
// Output channel out_*: zero or one result beat per input beat, packed as
// listed beside out_tdata / out_tuser.
// Each input beat is parsed by combinational logic, and its result is registered
// as the beat is taken. Throughput is one byte per cycle while in_tready is high;
// the one-byte CRC update is folded into the parse logic.
// A result register holds the pending beat. While it is full and unread,
// in_tready falls; it stays high while the register drains in the same cycle.
// Synchronous active-low reset returns the parser to hunting for a pad with
// all counters and CRC state cleared and the output register empty.
module zmodem_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  input  logic        in_tuser,   // timed_out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // byte_value[7:0], frame_type[15:8], frame_flags[47:16],
                                  // used_crc32[48], ender_code[56:49], payload_len[67:57],
                                  // error_code[69:68], zero[71:70]
  output logic [1:0]  out_tuser   // kind
);
  import zfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [3:0]  hnib_r, hnib_nxt;
  logic [39:0] hdr_r, hdr_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        is32_r, is32_nxt;
  logic [10:0] pcnt_r, pcnt_nxt;
  logic [1:0]  mode_r, mode_nxt;

  logic        ov_r;
  result_t     res_r, res_nxt;
  logic        emit;
  logic        take;

  assign in_tready = !ov_r || out_tready;
  assign take = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tuser = res_r.kind;
  assign out_tdata = {2'b00, res_r.error_code, res_r.payload_len, res_r.ender_code,
                      res_r.used_crc32, res_r.frame_flags, res_r.frame_type, res_r.byte_value};

  logic [7:0]  c;
  logic [4:0]  hv;   // bit 4 = invalid
  logic [7:0]  v;
  logic        ev_data, ev_ender;
  logic        is_end;
  logic [7:0]  fb;
  logic        feed, tk;
  logic [31:0] fed;
  logic [31:0] took;
  logic        match;
  logic [3:0]  fc1;

  always_comb begin
    c = in_tdata;
    if (c >= 8'h30 && c <= 8'h39) hv = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      hv = {1'b0, 4'(c[3:0] + 4'd9)};
    else hv = 5'h10;
    is_end = (c == END_E) || (c == END_G) || (c == END_Q) || (c == END_W);
    ev_data = 1'b0; ev_ender = 1'b0; v = c;
    if (esc_r) begin
      if (is_end) ev_ender = 1'b1;
      else begin ev_data = 1'b1; v = c ^ 8'h40; end
    end else if (c != DLE_CH) ev_data = 1'b1;
  end

  always_comb begin
    phase_nxt = phase_r; esc_nxt = esc_r; fcnt_nxt = fcnt_r; hnib_nxt = hnib_r;
    hdr_nxt = hdr_r; rcrc_nxt = rcrc_r; acc_nxt = acc_r; is32_nxt = is32_r;
    pcnt_nxt = pcnt_r; mode_nxt = mode_r;
    res_nxt = '0; emit = 1'b0;
    fb = v; feed = 1'b0; tk = 1'b0;
    fc1 = fcnt_r + 4'd1;

    // byte to feed / take is selected first, CRC math shared below
    case (phase_r)
      PH_HEX: if (!hv[4] && fcnt_r[0]) begin
        fb = {hnib_r, hv[3:0]};
        if (fcnt_r[3:1] < 3'd5) feed = 1'b1; else tk = 1'b1;
      end
      PH_BHDR: if (ev_data || ev_ender) begin
        if (fcnt_r < 4'd5) feed = 1'b1; else tk = 1'b1;
      end
      PH_SUBDATA: if (ev_ender || (ev_data && pcnt_r < 11'(MAX_PAYLOAD))) feed = 1'b1;
      PH_SUBCRC: if (ev_data || ev_ender) tk = 1'b1;
      default: ;
    endcase

    fed = is32_r ? crc32_byte(acc_r, fb) : {16'h0, crc16_byte(acc_r[15:0], fb)};
    took = is32_r ? {fb, rcrc_r[31:8]} : {16'h0, rcrc_r[7:0], fb};
    if (feed) acc_nxt = fed;
    if (tk) rcrc_nxt = took;
    match = is32_r ? ((acc_nxt ^ 32'hFFFFFFFF) == rcrc_nxt)
                   : (acc_nxt[15:0] == rcrc_nxt[15:0]);

    if (in_tuser) begin
      res_nxt.kind = KIND_ERR; res_nxt.error_code = ERR_TMO; emit = 1'b1;
      phase_nxt = PH_HUNT; esc_nxt = 1'b0; mode_nxt = MODE_NONE;
      acc_nxt = acc_r; rcrc_nxt = rcrc_r;
    end else begin
      case (phase_r)
        PH_HUNT: if (c == PAD_CH) phase_nxt = PH_PAD1;
        PH_PAD1: phase_nxt = (c == PAD_CH) ? PH_PAD2 : (c == DLE_CH) ? PH_FMT : PH_HUNT;
        PH_PAD2: phase_nxt = (c == DLE_CH) ? PH_FMT : PH_HUNT;
        PH_FMT: begin
          if (c == FMT_HEX || c == FMT_B16 || c == FMT_B32) begin
            phase_nxt = (c == FMT_HEX) ? PH_HEX : PH_BHDR;
            esc_nxt = 1'b0; fcnt_nxt = '0; hnib_nxt = '0; hdr_nxt = '0; rcrc_nxt = '0;
            is32_nxt = (c == FMT_B32);
            acc_nxt = (c == FMT_B32) ? 32'hFFFFFFFF : 32'h0;
          end else begin
            phase_nxt = PH_HUNT; esc_nxt = 1'b0; mode_nxt = MODE_NONE;
          end
        end
        PH_HEX, PH_HEXBAD: begin
          if (phase_r == PH_HEX) begin
            if (hv[4]) phase_nxt = PH_HEXBAD;
            else if (!fcnt_r[0]) hnib_nxt = hv[3:0];
            else if (fcnt_r[3:1] < 3'd5) hdr_nxt[fcnt_r[3:1]*8 +: 8] = fb;
          end
          fcnt_nxt = fc1;
          if (fc1 >= HDR_NIBBLES) begin
            emit = 1'b1;
            if (phase_r == PH_HEXBAD || hv[4]) begin
              res_nxt.kind = KIND_ERR; res_nxt.error_code = ERR_HEX;
              phase_nxt = PH_HUNT; esc_nxt = 1'b0; mode_nxt = MODE_NONE;
            end
          end
        end
        PH_BHDR: begin
          if (!ev_data && !ev_ender) esc_nxt = 1'b1;
          else begin
            esc_nxt = 1'b0;
            if (fcnt_r < 4'd5) hdr_nxt[fcnt_r[2:0]*8 +: 8] = fb;
            fcnt_nxt = fc1;
            if (fc1 >= (is32_r ? 4'd9 : 4'd7)) emit = 1'b1;
          end
        end
        PH_SUBDATA: begin
          if (!ev_data && !ev_ender) esc_nxt = 1'b1;
          else begin
            esc_nxt = 1'b0;
            if (ev_ender) begin
              hdr_nxt = {32'h0, c}; fcnt_nxt = '0; rcrc_nxt = '0; phase_nxt = PH_SUBCRC;
            end else if (feed) begin
              pcnt_nxt = pcnt_r + 11'd1;
              res_nxt.kind = KIND_DATA; res_nxt.byte_value = v; emit = 1'b1;
            end
          end
        end
        PH_SUBCRC: begin
          if (!ev_data && !ev_ender) esc_nxt = 1'b1;
          else begin
            esc_nxt = 1'b0;
            fcnt_nxt = fc1;
            if (fc1 >= (is32_r ? 4'd4 : 4'd2)) begin
              emit = 1'b1;
              if (!match) begin
                res_nxt.kind = KIND_ERR; res_nxt.error_code = ERR_SCRC;
                phase_nxt = PH_HUNT; mode_nxt = MODE_NONE;
              end else begin
                res_nxt.kind = KIND_END; res_nxt.used_crc32 = is32_r;
                res_nxt.ender_code = hdr_r[7:0]; res_nxt.payload_len = pcnt_r;
                if (mode_r == MODE_MANY && hdr_r[7:0] != END_E && hdr_r[7:0] != END_W) begin
                  phase_nxt = PH_SUBDATA; fcnt_nxt = '0; rcrc_nxt = '0; pcnt_nxt = '0;
                  acc_nxt = is32_r ? 32'hFFFFFFFF : 32'h0;
                end else begin
                  phase_nxt = PH_HUNT; mode_nxt = MODE_NONE;
                end
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT; esc_nxt = 1'b0; mode_nxt = MODE_NONE;
        end
      endcase

      // header completion (HEX good digits or binary)
      if (emit && (phase_r == PH_BHDR || (phase_r == PH_HEX && !hv[4]))) begin
        if (!match) begin
          res_nxt.kind = KIND_ERR; res_nxt.error_code = ERR_HCRC;
          phase_nxt = PH_HUNT; esc_nxt = 1'b0; mode_nxt = MODE_NONE;
        end else begin
          res_nxt.kind = KIND_HDR; res_nxt.frame_type = hdr_nxt[7:0];
          res_nxt.frame_flags = hdr_nxt[39:8]; res_nxt.used_crc32 = is32_r;
          if (hdr_nxt[7:0] == TYPE_FILE || hdr_nxt[7:0] == TYPE_DATA) begin
            phase_nxt = PH_SUBDATA; esc_nxt = 1'b0; fcnt_nxt = '0; rcrc_nxt = '0;
            pcnt_nxt = '0; acc_nxt = is32_r ? 32'hFFFFFFFF : 32'h0;
            mode_nxt = (hdr_nxt[7:0] == TYPE_FILE) ? MODE_ONE : MODE_MANY;
          end else begin
            phase_nxt = PH_HUNT; esc_nxt = 1'b0; mode_nxt = MODE_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT; esc_r <= 1'b0; fcnt_r <= '0; hnib_r <= '0; hdr_r <= '0;
      rcrc_r <= '0; acc_r <= '0; is32_r <= 1'b0; pcnt_r <= '0; mode_r <= MODE_NONE;
      ov_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; esc_r <= esc_nxt; fcnt_r <= fcnt_nxt; hnib_r <= hnib_nxt;
        hdr_r <= hdr_nxt; rcrc_r <= rcrc_nxt; acc_r <= acc_nxt; is32_r <= is32_nxt;
        pcnt_r <= pcnt_nxt; mode_r <= mode_nxt;
        ov_r <= emit;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) res_r <= res_nxt;
  end

endmodule

### tb/tb_zmodem_frame_receiver.sv
// Self-checking bench for zmodem_frame_receiver: random-gap byte stream in, stalled results out.
// A built-in parser model predicts every result beat; depends on zfr_pkg and the DUT.
module tb_zmodem_frame_receiver;
  import zfr_pkg::*;

  typedef struct packed {
    logic       tmo;
    logic [7:0] b;
  } rx_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  zmodem_frame_receiver DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  rx_item_t rx_bytes[$];
  result_t  expected_results[$];
  int       fail_count = 0;
  int       beats_taken = 0;

  // ---------------- parser model ----------------
  phase_t      m_phase = PH_HUNT;
  logic        m_esc = 0;
  logic [3:0]  m_fcnt = 0;
  logic [3:0]  m_nib = 0;
  logic [39:0] m_hdr = 0;
  logic [31:0] m_rcrc = 0;
  logic [31:0] m_acc = 0;
  logic        m_is32 = 0;
  logic [10:0] m_pcnt = 0;
  logic [1:0]  m_mode = MODE_NONE;

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  function automatic bit is_ender_ch(logic [7:0] c);
    return c == END_E || c == END_G || c == END_Q || c == END_W;
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function void acc_feed(logic [7:0] b);
    m_acc = m_is32 ? crc32_step(m_acc, b) : {16'h0, crc16_step(m_acc[15:0], b)};
  endfunction

  function void rcrc_take(logic [7:0] b);
    m_rcrc = m_is32 ? {b, m_rcrc[31:8]} : {16'h0, m_rcrc[7:0], b};
  endfunction

  function bit crc_ok();
    return m_is32 ? ((m_acc ^ 32'hFFFFFFFF) == m_rcrc) : (m_acc[15:0] == m_rcrc[15:0]);
  endfunction

  // 0 swallowed escape, 1 data, 2 ender
  function int unescape_byte(logic [7:0] c, output logic [7:0] v);
    v = c;
    if (m_esc) begin
      m_esc = 0;
      if (is_ender_ch(c)) return 2;
      v = c ^ 8'h40;
      return 1;
    end
    if (c == DLE_CH) begin
      m_esc = 1;
      return 0;
    end
    return 1;
  endfunction

  function void back_to_hunt();
    m_phase = PH_HUNT;
    m_esc = 0;
    m_mode = MODE_NONE;
  endfunction

  function void open_subpacket();
    m_phase = PH_SUBDATA;
    m_esc = 0;
    m_fcnt = 0;
    m_rcrc = 0;
    m_pcnt = 0;
    m_acc = m_is32 ? 32'hFFFFFFFF : 32'h0;
  endfunction

  function void open_header(phase_t p, logic is32);
    m_phase = p;
    m_esc = 0;
    m_fcnt = 0;
    m_nib = 0;
    m_hdr = 0;
    m_rcrc = 0;
    m_is32 = is32;
    m_acc = is32 ? 32'hFFFFFFFF : 32'h0;
  endfunction

  function void header_done(inout result_t r);
    if (!crc_ok()) begin
      r.kind = KIND_ERR;
      r.error_code = ERR_HCRC;
      back_to_hunt();
      return;
    end
    r.kind = KIND_HDR;
    r.frame_type = m_hdr[7:0];
    r.frame_flags = m_hdr[39:8];
    r.used_crc32 = m_is32;
    if (m_hdr[7:0] == TYPE_FILE) begin
      open_subpacket();
      m_mode = MODE_ONE;
    end else if (m_hdr[7:0] == TYPE_DATA) begin
      open_subpacket();
      m_mode = MODE_MANY;
    end else back_to_hunt();
  endfunction

  function void predict_byte(rx_item_t it);
    result_t    r;
    bit         have;
    logic [7:0] c, v, hb;
    int         ev, d;
    r = '0;
    have = 0;
    c = it.b;
    if (it.tmo) begin
      r.kind = KIND_ERR;
      r.error_code = ERR_TMO;
      back_to_hunt();
      expected_results.push_back(r);
      return;
    end
    case (m_phase)
      PH_HUNT: if (c == PAD_CH) m_phase = PH_PAD1;
      PH_PAD1: m_phase = (c == PAD_CH) ? PH_PAD2 : (c == DLE_CH) ? PH_FMT : PH_HUNT;
      PH_PAD2: m_phase = (c == DLE_CH) ? PH_FMT : PH_HUNT;
      PH_FMT: begin
        if (c == FMT_HEX) open_header(PH_HEX, 0);
        else if (c == FMT_B16) open_header(PH_BHDR, 0);
        else if (c == FMT_B32) open_header(PH_BHDR, 1);
        else back_to_hunt();
      end
      PH_HEX, PH_HEXBAD: begin
        d = hex_nibble(c);
        if (m_phase == PH_HEX && d < 0) m_phase = PH_HEXBAD;
        if (m_phase == PH_HEX) begin
          if (!m_fcnt[0]) m_nib = d[3:0];
          else begin
            hb = {m_nib, d[3:0]};
            if ((m_fcnt >> 1) < 5) begin
              m_hdr = m_hdr | (40'(hb) << (8 * (m_fcnt >> 1)));
              acc_feed(hb);
            end else rcrc_take(hb);
          end
        end
        m_fcnt = m_fcnt + 4'd1;
        if (m_fcnt >= HDR_NIBBLES) begin
          have = 1;
          if (m_phase == PH_HEXBAD) begin
            r.kind = KIND_ERR;
            r.error_code = ERR_HEX;
            back_to_hunt();
          end else header_done(r);
        end
      end
      PH_BHDR: begin
        ev = unescape_byte(c, v);
        if (ev != 0) begin
          if (m_fcnt < 5) begin
            m_hdr = m_hdr | (40'(v) << (8 * m_fcnt));
            acc_feed(v);
          end else rcrc_take(v);
          m_fcnt = m_fcnt + 4'd1;
          if (m_fcnt >= (m_is32 ? 9 : 7)) begin
            have = 1;
            header_done(r);
          end
        end
      end
      PH_SUBDATA: begin
        ev = unescape_byte(c, v);
        if (ev == 2) begin
          acc_feed(v);
          m_hdr = {32'h0, v};
          m_fcnt = 0;
          m_rcrc = 0;
          m_phase = PH_SUBCRC;
        end else if (ev == 1 && m_pcnt < MAX_PAYLOAD) begin
          m_pcnt = m_pcnt + 11'd1;
          acc_feed(v);
          have = 1;
          r.kind = KIND_DATA;
          r.byte_value = v;
        end
      end
      PH_SUBCRC: begin
        ev = unescape_byte(c, v);
        if (ev != 0) begin
          rcrc_take(v);
          m_fcnt = m_fcnt + 4'd1;
          if (m_fcnt >= (m_is32 ? 4 : 2)) begin
            have = 1;
            if (!crc_ok()) begin
              r.kind = KIND_ERR;
              r.error_code = ERR_SCRC;
              back_to_hunt();
            end else begin
              r.kind = KIND_END;
              r.used_crc32 = m_is32;
              r.ender_code = m_hdr[7:0];
              r.payload_len = m_pcnt;
              if (m_mode == MODE_MANY && m_hdr[7:0] != END_E && m_hdr[7:0] != END_W)
                open_subpacket();
              else back_to_hunt();
            end
          end
        end
      end
      default: back_to_hunt();
    endcase
    if (have) expected_results.push_back(r);
  endfunction

  // ---------------- stream builders ----------------
  function void put_raw(logic [7:0] b);
    rx_item_t it;
    it.tmo = 0;
    it.b = b;
    rx_bytes.push_back(it);
  endfunction

  function void put_timeout();
    rx_item_t it;
    it.tmo = 1;
    it.b = 8'($urandom);
    rx_bytes.push_back(it);
  endfunction

  // DLE must be escaped; others sometimes, unless the escaped form reads as an ender
  function void put_escaped(logic [7:0] b);
    if (b == DLE_CH || ($urandom_range(7) == 0 && !is_ender_ch(b ^ 8'h40))) begin
      put_raw(DLE_CH);
      put_raw(b ^ 8'h40);
    end else put_raw(b);
  endfunction

  function void put_hex_byte(logic [7:0] b);
    logic [3:0] n;
    for (int k = 1; k >= 0; k--) begin
      n = (k == 1) ? b[7:4] : b[3:0];
      if (n < 10) put_raw("0" + n);
      else put_raw(8'(($urandom_range(1) ? "a" : "A") + n - 10));
    end
  endfunction

  function void put_preamble(logic [7:0] fmt);
    put_raw(PAD_CH);
    if ($urandom_range(1)) put_raw(PAD_CH);
    put_raw(DLE_CH);
    put_raw(fmt);
  endfunction

  function void put_header(logic [7:0] fmt, logic [7:0] ftype, logic [31:0] flags);
    logic [7:0]  hb[5];
    logic [15:0] c16;
    logic [31:0] c32;
    hb[0] = ftype;
    for (int i = 0; i < 4; i++) hb[i+1] = flags[8*i +: 8];
    c16 = 0;
    c32 = 32'hFFFFFFFF;
    for (int i = 0; i < 5; i++) begin
      c16 = crc16_step(c16, hb[i]);
      c32 = crc32_step(c32, hb[i]);
    end
    c32 = c32 ^ 32'hFFFFFFFF;
    put_preamble(fmt);
    for (int i = 0; i < 5; i++) begin
      if (fmt == FMT_HEX) put_hex_byte(hb[i]);
      else put_escaped(hb[i]);
    end
    if (fmt == FMT_HEX) begin
      put_hex_byte(c16[15:8]);
      put_hex_byte(c16[7:0]);
    end else if (fmt == FMT_B16) begin
      put_escaped(c16[15:8]);
      put_escaped(c16[7:0]);
    end else
      for (int i = 0; i < 4; i++) put_escaped(c32[8*i +: 8]);
  endfunction

  function void put_subpacket(logic is32, int nbytes, logic [7:0] ender);
    logic [7:0]  b;
    logic [15:0] c16;
    logic [31:0] c32;
    int          kept;
    c16 = 0;
    c32 = 32'hFFFFFFFF;
    kept = 0;
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      if ($urandom_range(15) == 0) b = DLE_CH;
      put_escaped(b);
      if (kept < MAX_PAYLOAD) begin
        kept++;
        c16 = crc16_step(c16, b);
        c32 = crc32_step(c32, b);
      end
    end
    put_raw(DLE_CH);
    put_raw(ender);
    c16 = crc16_step(c16, ender);
    c32 = crc32_step(c32, ender) ^ 32'hFFFFFFFF;
    if (is32) for (int i = 0; i < 4; i++) put_escaped(c32[8*i +: 8]);
    else begin
      put_escaped(c16[15:8]);
      put_escaped(c16[7:0]);
    end
  endfunction

  function logic [7:0] pick_format();
    case ($urandom_range(2))
      0: return FMT_HEX;
      1: return FMT_B16;
      default: return FMT_B32;
    endcase
  endfunction

  function logic [7:0] pick_ender(bit closing);
    if (closing) return $urandom_range(1) ? END_E : END_W;
    return $urandom_range(1) ? END_G : END_Q;
  endfunction

  // one session: header and its subpackets, sometimes with a flipped bit or a timeout
  function void put_session();
    logic [7:0] fmt, ftype;
    int         start, nsub, r;
    logic       is32;
    start = rx_bytes.size();
    fmt = pick_format();
    is32 = (fmt == FMT_B32);
    r = $urandom_range(9);
    ftype = (r < 4) ? TYPE_DATA : (r < 7) ? TYPE_FILE : 8'($urandom);
    put_header(fmt, ftype, $urandom);
    if (ftype == TYPE_FILE)
      put_subpacket(is32, $urandom_range(0, 24), pick_ender(1'($urandom_range(1))));
    else if (ftype == TYPE_DATA) begin
      nsub = $urandom_range(1, 4);
      for (int i = 0; i < nsub; i++)
        put_subpacket(is32, $urandom_range(0, 24), pick_ender(i == nsub - 1));
    end
    r = $urandom_range(19);
    if (r == 0) rx_bytes[$urandom_range(start, rx_bytes.size() - 1)].b ^= 8'(1 << $urandom_range(7));
    else if (r == 1) rx_bytes.insert($urandom_range(start, rx_bytes.size() - 1),
                                     '{tmo: 1'b1, b: 8'($urandom)});
  endfunction

  // ---------------- sender ----------------
  int burst_left = 0;
  int gap_left = 0;
  bit beat_taken = 0;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_byte('{tmo: in_tuser, b: in_tdata});
      beat_taken = 1;
      beats_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || beat_taken) begin
      beat_taken = 0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (burst_left > 0 && rx_bytes.size() > 0) begin
        {in_tuser, in_tdata} <= rx_bytes.pop_front();
        in_tvalid <= 1'b1;
        burst_left--;
      end else begin
        in_tvalid <= 1'b0;
        if (burst_left == 0 && gap_left > 0) gap_left--;
      end
    end
  end

  // ---------------- receiver ----------------
  int  stall_mode = 0;
  int  mode_cycles = 0;
  int  hold_cycles = 0;
  bit  hold_done = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (!hold_done && beats_taken >= 400) begin
      hold_done = 1;
      hold_cycles = 300;
      out_tready <= 1'b0;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(2);
        mode_cycles = $urandom_range(16, 128);
      end
      mode_cycles--;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(1);
        default: out_tready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    result_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      a.kind = out_tuser;
      a.byte_value = out_tdata[7:0];
      a.frame_type = out_tdata[15:8];
      a.frame_flags = out_tdata[47:16];
      a.used_crc32 = out_tdata[48];
      a.ender_code = out_tdata[56:49];
      a.payload_len = out_tdata[67:57];
      a.error_code = out_tdata[69:68];
      if (expected_results.size() == 0) begin
        $error("unexpected result beat kind=%0d", a.kind);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (a.kind != e.kind) begin
          $error("kind exp %0d got %0d", e.kind, a.kind); fail_count++;
        end
        if (a.byte_value != e.byte_value) begin
          $error("byte_value exp %0h got %0h", e.byte_value, a.byte_value); fail_count++;
        end
        if (a.frame_type != e.frame_type) begin
          $error("frame_type exp %0h got %0h", e.frame_type, a.frame_type); fail_count++;
        end
        if (a.frame_flags != e.frame_flags) begin
          $error("frame_flags exp %0h got %0h", e.frame_flags, a.frame_flags); fail_count++;
        end
        if (a.used_crc32 != e.used_crc32) begin
          $error("used_crc32 exp %0d got %0d", e.used_crc32, a.used_crc32); fail_count++;
        end
        if (a.ender_code != e.ender_code) begin
          $error("ender_code exp %0h got %0h", e.ender_code, a.ender_code); fail_count++;
        end
        if (a.payload_len != e.payload_len) begin
          $error("payload_len exp %0d got %0d", e.payload_len, a.payload_len); fail_count++;
        end
        if (a.error_code != e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, a.error_code); fail_count++;
        end
      end
    end
  end

  // ---------------- stimulus and end of run ----------------
  initial begin
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    rst_n = 1'b0;
    // directed: header formats, case mix, flag extremes, FILE and DATA subpackets
    put_header(FMT_HEX, 8'h00, 32'h0000_0000);
    put_header(FMT_HEX, 8'hFF, 32'hFFFF_FFFF);
    put_header(FMT_B16, 8'h18, 32'h1818_1818);
    put_header(FMT_B32, TYPE_FILE, 32'h8000_0001);
    put_subpacket(1, 3, END_W);
    put_header(FMT_B16, TYPE_DATA, 32'h0);
    put_subpacket(0, 0, END_G);
    put_subpacket(0, 2, END_Q);
    put_subpacket(0, 1, END_E);
    // bad hex digit mid-header
    put_preamble(FMT_HEX);
    for (int i = 0; i < 14; i++) put_raw(i == 5 ? "z" : "0");
    // broken preamble, unknown format, timeout
    put_raw(PAD_CH); put_raw(8'h55);
    put_raw(PAD_CH); put_raw(DLE_CH); put_raw(8'h44);
    put_header(FMT_B32, TYPE_DATA, 32'h1234_5678);
    put_raw(8'h41);
    put_timeout();
    // bad header and subpacket CRC
    put_header(FMT_B16, 8'h03, 32'h0);
    rx_bytes[rx_bytes.size() - 1].b ^= 8'h01;
    put_header(FMT_HEX, TYPE_FILE, 32'h0);
    put_subpacket(0, 4, END_E);
    rx_bytes[rx_bytes.size() - 1].b ^= 8'h80;
    // long payload past the limit
    put_header(FMT_B32, TYPE_FILE, 32'h0);
    put_subpacket(1, MAX_PAYLOAD + 6, END_W);
    // random sessions with noise
    while (rx_bytes.size() < 2000) begin
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 4)) put_raw($urandom_range(1) ? 8'($urandom) : PAD_CH);
      put_session();
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (rx_bytes.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) fail_count++;
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
